// ===== src/pulse_capture_cleanup_analysis_core_assert.svh =====
// assertion helpers
`ifndef PULSE_CAPTURE_CLEANUP_ANALYSIS_CORE_ASSERT_SVH
`define PULSE_CAPTURE_CLEANUP_ANALYSIS_CORE_ASSERT_SVH

`define PCCA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define PCCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pcca_pkg.sv =====
package pcca_pkg;

  typedef struct packed {
    logic        is_sum;
    logic        no_sig;
    logic        level;
    logic [31:0] data;
  } cmd_t;

  localparam int CMD_DEPTH = 4;

  typedef enum logic [2:0] {
    REG_START_LEVEL  = 3'd0,
    REG_GLITCH_LIMIT = 3'd1,
    REG_LEAD_SILENCE = 3'd2,
    REG_UNIT_MIN     = 3'd3,
    REG_UNIT_MAX     = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_U_RD,
    B_U_CMP,
    B_P_RDA,
    B_P_RDB,
    B_P_CMP,
    B_F_CHK,
    B_F_RDA,
    B_F_RDB,
    B_F_MUL,
    B_F_CMP,
    B_DIV,
    B_EMIT
  } back_state_t;

  localparam logic [31:0] DIV5_RECIP = 32'hCCCC_CCCD;
  localparam logic [31:0] TOL_FLOOR  = 32'd80;
  localparam int          MAX_BITS   = 64;
  localparam int          MIN_FRAME  = 8;
  localparam int          PWM_MIN    = 8;
  localparam logic [7:0]  REP_SAT    = 8'd255;

endpackage

// ===== src/pulse_capture_cleanup_analysis_core.sv =====
// Pulse capture clean-up and analysis. Raw pulse durations are pushed one per
// word; glitches and a leading silence are folded out on the fly and each
// cleaned pulse comes out as a kind-0 word. A word marked last ends the
// capture: the stored pulses are scanned for the unit time, PWM bits and a
// repeating frame, then one kind-1 summary word follows. Cleaning takes a new raw
// pulse when no word waits for the four-word command queue, or when one waits and
// the queue has room, so a raw word that yields two or three words holds input
// until no more than one waits. The summary is worked out through the single read
// port of the pulse memory and a repeat count divider that subtracts the frame
// length one step at a time. The user must write configuration only while idle;
// the block itself does not enforce this.
module pulse_capture_cleanup_analysis_core #(
  parameter int MAX_PULSE_COUNT = 8192,
  parameter int MAX_FRAME_LEN   = 512
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [2:0]                           cfg_index,
  input  logic [31:0]                          cfg_wdata,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic [31:0]                          in_duration,
  input  logic                                 in_last,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic                                 out_kind,
  output logic [31:0]                          out_pulse_duration,
  output logic                                 out_final_res,
  output logic [$clog2(MAX_PULSE_COUNT+1)-1:0] out_pulse_count,
  output logic                                 out_level_at_start,
  output logic                                 out_no_signal,
  output logic [15:0]                          out_unit_time,
  output logic [6:0]                           out_bits_decoded,
  output logic [63:0]                          out_key,
  output logic                                 out_pwm_found,
  output logic [$clog2(MAX_FRAME_LEN+1)-1:0]   out_frame_len,
  output logic [7:0]                           out_repeats
);
  import pcca_pkg::*;

  logic        start_level_r;
  logic [15:0] glitch_limit_r;
  logic [31:0] lead_silence_r;
  logic [15:0] unit_min_r;
  logic [15:0] unit_max_r;

  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_level_r  <= 1'b0;
      glitch_limit_r <= 16'd80;
      lead_silence_r <= 32'd20000;
      unit_min_r     <= 16'd100;
      unit_max_r     <= 16'd2000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_LEVEL:  start_level_r  <= cfg_wdata[0];
        REG_GLITCH_LIMIT: glitch_limit_r <= cfg_wdata[15:0];
        REG_LEAD_SILENCE: lead_silence_r <= cfg_wdata;
        REG_UNIT_MIN:     unit_min_r     <= cfg_wdata[15:0];
        REG_UNIT_MAX:     unit_max_r     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  pcca_front #(.MAX_PULSE_COUNT(MAX_PULSE_COUNT)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_duration  (in_duration),
    .in_last      (in_last),
    .start_level  (start_level_r),
    .glitch_limit (glitch_limit_r),
    .lead_silence (lead_silence_r),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in),
    .cmd_full     (cmd_full)
  );

  pcca_cmd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  pcca_back #(
    .MAX_PULSE_COUNT (MAX_PULSE_COUNT),
    .MAX_FRAME_LEN   (MAX_FRAME_LEN)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd_out),
    .cmd_empty          (cmd_empty),
    .cmd_pop            (cmd_pop),
    .unit_min           (unit_min_r),
    .unit_max           (unit_max_r),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_kind           (out_kind),
    .out_pulse_duration (out_pulse_duration),
    .out_final_res      (out_final_res),
    .out_pulse_count    (out_pulse_count),
    .out_level_at_start (out_level_at_start),
    .out_no_signal      (out_no_signal),
    .out_unit_time      (out_unit_time),
    .out_bits_decoded   (out_bits_decoded),
    .out_key            (out_key),
    .out_pwm_found      (out_pwm_found),
    .out_frame_len      (out_frame_len),
    .out_repeats        (out_repeats)
  );

endmodule

// ===== src/pcca_front.sv =====
module pcca_front #(
  parameter int MAX_PULSE_COUNT = 8192
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic [31:0]   in_duration,
  input  logic          in_last,
  input  logic          start_level,
  input  logic [15:0]   glitch_limit,
  input  logic [31:0]   lead_silence,
  output logic          cmd_push,
  output pcca_pkg::cmd_t cmd,
  input  logic          cmd_full
);
  import pcca_pkg::*;

  localparam int CW = $clog2(MAX_PULSE_COUNT + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_PULSE_COUNT);

  logic [31:0]   held_r, held_nxt;
  logic          held_valid_r, held_valid_nxt;
  logic          absorb_r, absorb_nxt;
  logic [CW-1:0] raw_r, raw_nxt;
  logic [CW-1:0] clean_r, clean_nxt;
  logic          flip_r, flip_nxt;
  cmd_t          pend_r [3];
  cmd_t          pend_nxt [3];
  logic [1:0]    pcnt_r, pcnt_nxt;

  logic accept;

  assign in_full  = (pcnt_r > 2'd1) || (pcnt_r == 2'd1 && cmd_full);
  assign accept   = in_push && !in_full;
  assign cmd_push = (pcnt_r != 2'd0) && !cmd_full;
  assign cmd      = pend_r[0];

  always_comb begin
    cmd_t          cl [3];
    logic [1:0]    nc;
    logic          done;
    logic          final_raw;
    logic [CW-1:0] raw_n;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    absorb_nxt     = absorb_r;
    raw_nxt        = raw_r;
    clean_nxt      = clean_r;
    flip_nxt       = flip_r;
    cl[0] = '0;
    cl[1] = '0;
    cl[2] = '0;
    nc        = 2'd0;
    done      = 1'b0;
    final_raw = 1'b0;
    raw_n     = raw_r + 1'b1;
    if (accept) begin
      if (raw_r < MAXC) begin
        raw_nxt   = raw_n;
        final_raw = in_last || (raw_n == MAXC);
        if (raw_r == '0 && in_last) begin
          cl[nc] = '{is_sum: 1'b1, no_sig: 1'b1, level: start_level, data: 32'd0};
          nc = nc + 2'd1;
          done = 1'b1;
        end else if (absorb_r) begin
          held_nxt   = held_r + in_duration;
          absorb_nxt = 1'b0;
        end else if (raw_r == '0 && in_duration > lead_silence) begin
          flip_nxt = 1'b1;
        end else if (in_duration < {16'd0, glitch_limit} && !final_raw && held_valid_r) begin
          held_nxt   = held_r + in_duration;
          absorb_nxt = 1'b1;
        end else begin
          if (held_valid_r) begin
            held_valid_nxt = 1'b0;
            if (clean_r < MAXC) begin
              cl[nc] = '{is_sum: 1'b0, no_sig: 1'b0, level: 1'b0, data: held_r};
              nc = nc + 2'd1;
              clean_nxt = clean_r + 1'b1;
            end
          end
          held_nxt       = in_duration;
          held_valid_nxt = 1'b1;
        end
      end
      if (in_last && !done) begin
        if (held_valid_nxt) begin
          if (clean_nxt < MAXC) begin
            cl[nc] = '{is_sum: 1'b0, no_sig: 1'b0, level: 1'b0, data: held_nxt};
            nc = nc + 2'd1;
            clean_nxt = clean_nxt + 1'b1;
          end
        end
        cl[nc] = '{is_sum: 1'b1, no_sig: 1'b0, level: start_level ^ flip_nxt,
                   data: 32'(clean_nxt)};
        nc = nc + 2'd1;
        done = 1'b1;
      end
      if (done) begin
        held_nxt       = '0;
        held_valid_nxt = 1'b0;
        absorb_nxt     = 1'b0;
        raw_nxt        = '0;
        clean_nxt      = '0;
        flip_nxt       = 1'b0;
      end
      pend_nxt[0] = cl[0];
      pend_nxt[1] = cl[1];
      pend_nxt[2] = cl[2];
      pcnt_nxt    = nc;
    end else if (cmd_push) begin
      pend_nxt[0] = pend_r[1];
      pend_nxt[1] = pend_r[2];
      pend_nxt[2] = pend_r[2];
      pcnt_nxt    = pcnt_r - 2'd1;
    end else begin
      pend_nxt[0] = pend_r[0];
      pend_nxt[1] = pend_r[1];
      pend_nxt[2] = pend_r[2];
      pcnt_nxt    = pcnt_r;
    end
  end

  always_ff @(posedge clk) begin
    pend_r[0] <= pend_nxt[0];
    pend_r[1] <= pend_nxt[1];
    pend_r[2] <= pend_nxt[2];
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      absorb_r     <= 1'b0;
      raw_r        <= '0;
      clean_r      <= '0;
      flip_r       <= 1'b0;
      pcnt_r       <= 2'd0;
      held_r       <= '0;
    end else begin
      held_valid_r <= held_valid_nxt;
      absorb_r     <= absorb_nxt;
      raw_r        <= raw_nxt;
      clean_r      <= clean_nxt;
      flip_r       <= flip_nxt;
      pcnt_r       <= pcnt_nxt;
      held_r       <= held_nxt;
    end
  end

endmodule

// ===== src/pcca_cmd_fifo.sv =====
`include "pulse_capture_cleanup_analysis_core_assert.svh"

module pcca_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pcca_pkg::cmd_t wdata,
  output logic           full,
  input  logic           pop,
  output pcca_pkg::cmd_t rdata,
  output logic           empty
);
  import pcca_pkg::*;

  localparam int PW = $clog2(CMD_DEPTH);
  localparam int NW = $clog2(CMD_DEPTH + 1);

  cmd_t          q_r [CMD_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == NW'(CMD_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + NW'(push) - NW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= wdata;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `PCCA_ASSERT_NOW(a_no_overflow, push, !full || pop, "push into full command queue")
  `PCCA_ASSERT_NOW(a_no_underflow, pop, !empty, "pop from empty command queue")
  `PCCA_ASSERT_NEXT(a_push_lands, push && !pop, !empty, "pushed word not visible")
  `PCCA_ASSERT_NOW(a_count_bound, 1'b1, cnt_r <= NW'(CMD_DEPTH), "queue count out of range")

endmodule

// ===== src/pcca_back.sv =====
module pcca_back #(
  parameter int MAX_PULSE_COUNT = 8192,
  parameter int MAX_FRAME_LEN   = 512
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  pcca_pkg::cmd_t                         cmd,
  input  logic                                   cmd_empty,
  output logic                                   cmd_pop,
  input  logic [15:0]                            unit_min,
  input  logic [15:0]                            unit_max,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic                                   out_kind,
  output logic [31:0]                            out_pulse_duration,
  output logic                                   out_final_res,
  output logic [$clog2(MAX_PULSE_COUNT+1)-1:0]   out_pulse_count,
  output logic                                   out_level_at_start,
  output logic                                   out_no_signal,
  output logic [15:0]                            out_unit_time,
  output logic [6:0]                             out_bits_decoded,
  output logic [63:0]                            out_key,
  output logic                                   out_pwm_found,
  output logic [$clog2(MAX_FRAME_LEN+1)-1:0]     out_frame_len,
  output logic [7:0]                             out_repeats
);
  import pcca_pkg::*;

  localparam int CW  = $clog2(MAX_PULSE_COUNT + 1);
  localparam int AW  = $clog2(MAX_PULSE_COUNT);
  localparam int FW  = $clog2(MAX_FRAME_LEN + 2);
  localparam int FLW = $clog2(MAX_FRAME_LEN + 1);

  logic [31:0] mem [MAX_PULSE_COUNT];
  logic [31:0] rdata_r;
  logic [AW-1:0] raddr;
  logic          we;

  back_state_t   st_r, st_nxt;
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          lvl_r, lvl_nxt;
  logic          nos_r, nos_nxt;
  logic [15:0]   te_r, te_nxt;
  logic [6:0]    bits_r, bits_nxt;
  logic [63:0]   key_r, key_nxt;
  logic [FW-1:0] f_r, f_nxt;
  logic [FW-1:0] frame_r, frame_nxt;
  logic [31:0]   a_r, a_nxt;
  logic [31:0]   b_r, b_nxt;
  logic [63:0]   prod_r, prod_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [7:0]    q_r, q_nxt;

  logic          ov_r, ov_nxt;
  logic          okind_r, okind_nxt;
  logic [31:0]   odur_r, odur_nxt;
  logic          out_free;

  assign out_free = !ov_r || out_pop;

  always_comb begin
    logic [31:0] big;
    logic [31:0] tol;
    logic        sa, sb;
    st_nxt    = st_r;
    wptr_nxt  = wptr_r;
    i_nxt     = i_r;
    cnt_nxt   = cnt_r;
    lvl_nxt   = lvl_r;
    nos_nxt   = nos_r;
    te_nxt    = te_r;
    bits_nxt  = bits_r;
    key_nxt   = key_r;
    f_nxt     = f_r;
    frame_nxt = frame_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    ov_nxt    = out_pop ? 1'b0 : ov_r;
    okind_nxt = okind_r;
    odur_nxt  = odur_r;
    cmd_pop   = 1'b0;
    we        = 1'b0;
    raddr     = '0;
    big       = (a_r > rdata_r) ? a_r : rdata_r;
    tol       = {2'b00, prod_r[63:34]};
    if (tol < TOL_FLOOR) begin
      tol = TOL_FLOOR;
    end
    sa = a_r < {15'd0, te_r, 1'b0};
    sb = rdata_r < {15'd0, te_r, 1'b0};
    case (st_r)
      B_IDLE: begin
        if (!cmd_empty && out_free) begin
          if (cmd.is_sum) begin
            cmd_pop   = 1'b1;
            cnt_nxt   = cmd.no_sig ? '0 : cmd.data[CW-1:0];
            lvl_nxt   = cmd.level;
            nos_nxt   = cmd.no_sig;
            te_nxt    = '0;
            bits_nxt  = '0;
            key_nxt   = '0;
            frame_nxt = '0;
            q_nxt     = '0;
            i_nxt     = '0;
            wptr_nxt  = '0;
            st_nxt    = cmd.no_sig ? B_EMIT : B_U_RD;
          end else begin
            cmd_pop   = 1'b1;
            we        = 1'b1;
            wptr_nxt  = wptr_r + 1'b1;
            ov_nxt    = 1'b1;
            okind_nxt = 1'b0;
            odur_nxt  = cmd.data;
          end
        end
      end
      B_U_RD: begin
        if (i_r < cnt_r) begin
          raddr  = i_r[AW-1:0];
          st_nxt = B_U_CMP;
        end else begin
          i_nxt  = '0;
          f_nxt  = FW'(MIN_FRAME);
          st_nxt = (te_r != '0) ? B_P_RDA : B_F_CHK;
        end
      end
      B_U_CMP: begin
        if (rdata_r >= {16'd0, unit_min} && rdata_r <= {16'd0, unit_max} &&
            (te_r == '0 || rdata_r < {16'd0, te_r})) begin
          te_nxt = rdata_r[15:0];
        end
        i_nxt  = i_r + 1'b1;
        st_nxt = B_U_RD;
      end
      B_P_RDA: begin
        if (({1'b0, i_r} + 1'b1) < {1'b0, cnt_r} && bits_r < 7'(MAX_BITS)) begin
          raddr  = i_r[AW-1:0];
          st_nxt = B_P_RDB;
        end else begin
          i_nxt  = '0;
          st_nxt = B_F_CHK;
        end
      end
      B_P_RDB: begin
        a_nxt  = rdata_r;
        raddr  = AW'(i_r + 1'b1);
        st_nxt = B_P_CMP;
      end
      B_P_CMP: begin
        if (sa == sb) begin
          bits_nxt = '0;
          key_nxt  = '0;
          i_nxt    = '0;
          st_nxt   = B_F_CHK;
        end else begin
          key_nxt  = {key_r[62:0], (!sa && sb)};
          bits_nxt = bits_r + 1'b1;
          i_nxt    = i_r + 2'd2;
          st_nxt   = B_P_RDA;
        end
      end
      B_F_CHK: begin
        if ((32'(f_r) << 1) <= 32'(cnt_r) && 32'(f_r) <= 32'(MAX_FRAME_LEN)) begin
          i_nxt  = '0;
          st_nxt = B_F_RDA;
        end else begin
          st_nxt = B_EMIT;
        end
      end
      B_F_RDA: begin
        if (32'(i_r) < 32'(f_r)) begin
          raddr  = i_r[AW-1:0];
          st_nxt = B_F_RDB;
        end else begin
          frame_nxt = f_r;
          rem_nxt   = cnt_r;
          st_nxt    = B_DIV;
        end
      end
      B_F_RDB: begin
        a_nxt  = rdata_r;
        raddr  = AW'(32'(i_r) + 32'(f_r));
        st_nxt = B_F_MUL;
      end
      B_F_MUL: begin
        b_nxt    = rdata_r;
        prod_nxt = big * DIV5_RECIP;
        st_nxt   = B_F_CMP;
      end
      B_F_CMP: begin
        if (a_r > b_r + tol || b_r > a_r + tol) begin
          f_nxt  = f_r + 1'b1;
          st_nxt = B_F_CHK;
        end else begin
          i_nxt  = i_r + 1'b1;
          st_nxt = B_F_RDA;
        end
      end
      B_DIV: begin
        if (32'(rem_r) >= 32'(frame_r) && q_r < REP_SAT) begin
          rem_nxt = CW'(32'(rem_r) - 32'(frame_r));
          q_nxt   = q_r + 1'b1;
        end else begin
          st_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = 1'b1;
          odur_nxt  = '0;
          st_nxt    = B_IDLE;
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wptr_r] <= cmd.data;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    cnt_r   <= cnt_nxt;
    lvl_r   <= lvl_nxt;
    nos_r   <= nos_nxt;
    te_r    <= te_nxt;
    bits_r  <= bits_nxt;
    key_r   <= key_nxt;
    f_r     <= f_nxt;
    frame_r <= frame_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    okind_r <= okind_nxt;
    odur_r  <= odur_nxt;
    if (!rst_n) begin
      st_r   <= B_IDLE;
      wptr_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      wptr_r <= wptr_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign out_empty          = !ov_r;
  assign out_kind           = okind_r;
  assign out_pulse_duration = odur_r;
  assign out_final_res      = okind_r;
  assign out_pulse_count    = okind_r ? cnt_r : '0;
  assign out_level_at_start = okind_r & lvl_r;
  assign out_no_signal      = okind_r & nos_r;
  assign out_unit_time      = okind_r ? te_r : '0;
  assign out_bits_decoded   = okind_r ? bits_r : '0;
  assign out_key            = okind_r ? key_r : '0;
  assign out_pwm_found      = okind_r && (bits_r >= 7'(PWM_MIN));
  assign out_frame_len      = okind_r ? FLW'(frame_r) : '0;
  assign out_repeats        = okind_r ? q_r : '0;

endmodule
